/* design/bcc_pkg.sv */
package bcc_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned CfgW   = 17;
  localparam int unsigned OpW    = 2;
  localparam int unsigned InodeW = 12;
  localparam int unsigned ModeW  = 16;
  localparam int unsigned PtrW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IssueW = 2;

  // Bitmap geometry: the used-block map is stored as rows of WordBits bits.
  localparam int unsigned MaxBlocks = 65536;
  localparam int unsigned WordBits  = (MaxBlocks < 64) ? MaxBlocks : 64;
  localparam int unsigned WordIdxW  = $clog2(WordBits);
  localparam int unsigned Rows      = MaxBlocks / WordBits;
  localparam int unsigned RowW      = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned BlockW    = $clog2(MaxBlocks);
  localparam int unsigned LimitW    = BlockW + 1;

  typedef enum logic [0:0] {
    CfgBlockCount     = 1'b0,
    CfgReservedBlocks = 1'b1
  } cfg_idx_e;

  typedef enum logic [OpW-1:0] {
    OpBegin   = 2'd0,
    OpHeader  = 2'd1,
    OpPointer = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KindDirect   = 2'd0,
    KindIndirect = 2'd1,
    KindEntry    = 2'd2,
    KindUnknown  = 2'd3
  } kind_e;

  typedef enum logic [IssueW-1:0] {
    IssueBadMode    = 2'd0,
    IssueBadPointer = 2'd1,
    IssueDuplicate  = 2'd2
  } issue_e;

  typedef enum logic [0:0] {
    SwIdle = 1'b0,
    SwRun  = 1'b1
  } sweep_state_e;

  // Write port driven by the bitmap sweep, plus its busy flag.
  typedef struct packed {
    logic                busy;
    logic                we;
    logic [RowW-1:0]     addr;
    logic [WordBits-1:0] data;
  } sweep_ctl_t;

  // Register values above the bitmap size act as the bitmap size.
  function automatic logic [LimitW-1:0] clamp_blocks(logic [CfgW-1:0] v);
    logic [LimitW-1:0] r;
    if (v > CfgW'(MaxBlocks)) begin
      r = LimitW'(MaxBlocks);
    end else begin
      r = LimitW'(v);
    end
    return r;
  endfunction

endpackage

/* design/bcc_in_if.sv */
interface bcc_in_if;
  logic                              valid;
  logic                              ready;
  logic        [bcc_pkg::OpW-1:0]    operation;
  logic        [bcc_pkg::InodeW-1:0] inode_number;
  logic        [bcc_pkg::ModeW-1:0]  inode_mode;
  logic signed [bcc_pkg::PtrW-1:0]   pointer_value;
  logic        [bcc_pkg::KindW-1:0]  pointer_kind;

  modport source (
    output valid, operation, inode_number, inode_mode, pointer_value, pointer_kind,
    input  ready
  );
  modport sink (
    input  valid, operation, inode_number, inode_mode, pointer_value, pointer_kind,
    output ready
  );
endinterface

/* design/bcc_out_if.sv */
interface bcc_out_if;
  logic                              valid;
  logic                              ready;
  logic        [bcc_pkg::IssueW-1:0] issue_kind;
  logic        [bcc_pkg::InodeW-1:0] issue_inode;
  logic signed [bcc_pkg::PtrW-1:0]   issue_block;
  logic        [bcc_pkg::KindW-1:0]  issue_pointer_kind;
  logic        [bcc_pkg::ModeW-1:0]  issue_mode;

  modport source (
    output valid, issue_kind, issue_inode, issue_block, issue_pointer_kind, issue_mode,
    input  ready
  );
  modport sink (
    input  valid, issue_kind, issue_inode, issue_block, issue_pointer_kind, issue_mode,
    output ready
  );
endinterface

/* design/bcc_ram.sv */
module bcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/bcc_sweep.sv */
module bcc_sweep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bcc_pkg::LimitW-1:0]    reserved_i,
  output bcc_pkg::sweep_ctl_t           ctl_o
);

  localparam int unsigned RhiW = bcc_pkg::LimitW - bcc_pkg::WordIdxW;

  bcc_pkg::sweep_state_e        state_q, state_d;
  logic [bcc_pkg::RowW-1:0]     row_q, row_d;
  logic                         fill_q, fill_d;
  logic [RhiW-1:0]              res_row;
  logic [bcc_pkg::WordIdxW-1:0] res_bit;
  logic [bcc_pkg::WordBits-1:0] part_mask;
  logic [bcc_pkg::WordBits-1:0] row_mask;

  // The pass after reset clears the map; a begin pass marks reserved blocks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcc_pkg::SwRun;
      row_q   <= '0;
      fill_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      fill_q  <= fill_d;
    end
  end

  // Row word of the reserved prefix: full rows, one partial row, then zero.
  assign res_row   = reserved_i[bcc_pkg::LimitW-1:bcc_pkg::WordIdxW];
  assign res_bit   = reserved_i[bcc_pkg::WordIdxW-1:0];
  assign part_mask = (bcc_pkg::WordBits'(1) << res_bit) - bcc_pkg::WordBits'(1);

  always_comb begin
    priority if (!fill_q) begin
      row_mask = '0;
    end else if (RhiW'(row_q) < res_row) begin
      row_mask = '1;
    end else if (RhiW'(row_q) == res_row) begin
      row_mask = part_mask;
    end else begin
      row_mask = '0;
    end
  end

  // Next state and the write port.
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    fill_d     = fill_q;
    ctl_o.busy = 1'b0;
    ctl_o.we   = 1'b0;
    ctl_o.addr = row_q;
    ctl_o.data = row_mask;
    unique case (state_q)
      bcc_pkg::SwIdle: begin
        if (start_i) begin
          state_d = bcc_pkg::SwRun;
          row_d   = '0;
          fill_d  = 1'b1;
        end
      end
      bcc_pkg::SwRun: begin
        ctl_o.busy = 1'b1;
        ctl_o.we   = 1'b1;
        if (row_q == bcc_pkg::RowW'(bcc_pkg::Rows - 1)) begin
          state_d = bcc_pkg::SwIdle;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      default: begin
        state_d = bcc_pkg::SwIdle;
      end
    endcase
  end

endmodule

/* design/block_reference_checker.sv */
// Block reference checker.
// Input beats on in_i carry a begin, an inode header or a block pointer.
// Output beats on out_o carry at most one issue per input beat: an invalid
// inode mode, an invalid block pointer or a duplicate block.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle:
// index 0 is the block count, index 1 the number of reserved leading blocks.
// The used-block bitmap lives in a RAM of Rows words of WordBits bits
// (1024 x 64). Each beat is read from the bitmap in the cycle it is taken;
// the check stage then checks it and writes its row back, with the word of
// the preceding write forwarded, and reports an issue through the output
// register on out_o, so header and pointer beats flow at one per cycle while
// the receiver takes results.
// A begin beat starts a sweep of the bitmap, one row per cycle, so no input
// is taken from the begin until the sweep has ended.
// After reset the same sweep clears the bitmap: in_i.ready stays low until
// it ends; configuration writes are taken meanwhile.
// When the receiver stalls, the result waits in the output register; the
// next beat is still taken into the check stage and waits there, and
// in_i.ready stays low while it waits.
module block_reference_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [bcc_pkg::CfgW-1:0]   cfg_data_i,
  bcc_in_if.sink                     in_i,
  bcc_out_if.source                  out_o
);

  // Configuration registers.
  logic [bcc_pkg::CfgW-1:0] block_count_q;
  logic [bcc_pkg::CfgW-1:0] reserved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= bcc_pkg::CfgW'(65536);
      reserved_q    <= bcc_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (bcc_pkg::cfg_idx_e'(cfg_idx_i))
        bcc_pkg::CfgBlockCount:     block_count_q <= cfg_data_i;
        bcc_pkg::CfgReservedBlocks: reserved_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [bcc_pkg::LimitW-1:0] limit;
  logic [bcc_pkg::LimitW-1:0] reserved;
  assign limit    = bcc_pkg::clamp_blocks(block_count_q);
  assign reserved = bcc_pkg::clamp_blocks(reserved_q);

  // Check stage registers: the beat whose bitmap row is being read.
  logic                         s1_valid_q;
  bcc_pkg::op_e                 s1_op_q;
  logic [bcc_pkg::InodeW-1:0]   s1_ino_q;
  logic [bcc_pkg::ModeW-1:0]    s1_mode_q;
  logic [bcc_pkg::PtrW-1:0]     s1_ptr_q;
  bcc_pkg::kind_e               s1_kind_q;

  // Inode context.
  logic [bcc_pkg::InodeW-1:0]   cur_ino_q, cur_ino_d;
  logic                         enabled_q, enabled_d;
  logic                         skip_q, skip_d;

  // Forwarding of the last bitmap write.
  logic                         fwd_valid_q;
  logic [bcc_pkg::RowW-1:0]     fwd_row_q;
  logic [bcc_pkg::WordBits-1:0] fwd_data_q;

  // Output register.
  logic                         out_valid_q;
  bcc_pkg::issue_e              out_kind_q;
  logic [bcc_pkg::InodeW-1:0]   out_ino_q;
  logic [bcc_pkg::PtrW-1:0]     out_block_q;
  logic [bcc_pkg::KindW-1:0]    out_pk_q;
  logic [bcc_pkg::ModeW-1:0]    out_mode_q;

  bcc_pkg::sweep_ctl_t          sweep;
  logic                         out_free;
  logic                         s1_go;
  logic                         in_take;
  logic [bcc_pkg::RowW-1:0]     in_row;
  logic [bcc_pkg::RowW-1:0]     s1_row;
  logic [bcc_pkg::RowW-1:0]     rd_addr;
  logic [bcc_pkg::WordBits-1:0] ram_rdata;
  logic [bcc_pkg::WordBits-1:0] rd_word;
  logic [bcc_pkg::WordBits-1:0] set_word;
  logic                         bit_used;
  logic                         out_of_range;
  logic                         s1_we;
  logic                         s1_emit;
  bcc_pkg::issue_e              s1_issue;
  logic                         ram_we;
  logic [bcc_pkg::RowW-1:0]     ram_waddr;
  logic [bcc_pkg::WordBits-1:0] ram_wdata;

  // Handshake: a begin in the check stage blocks input until its sweep ends.
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_go    = s1_valid_q && out_free;
  assign in_i.ready = !sweep.busy && !(s1_valid_q && (s1_op_q == bcc_pkg::OpBegin))
                      && (!s1_valid_q || out_free);
  assign in_take  = in_i.valid && in_i.ready;

  // Row addresses; a stalled beat rereads its row so the word stays fresh.
  assign in_row  = in_i.pointer_value[bcc_pkg::BlockW-1:bcc_pkg::WordIdxW];
  assign s1_row  = s1_ptr_q[bcc_pkg::BlockW-1:bcc_pkg::WordIdxW];
  assign rd_addr = (s1_valid_q && !s1_go) ? s1_row : in_row;

  assign rd_word  = (fwd_valid_q && (fwd_row_q == s1_row)) ? fwd_data_q : ram_rdata;
  assign bit_used = rd_word[s1_ptr_q[bcc_pkg::WordIdxW-1:0]];
  assign set_word = rd_word | (bcc_pkg::WordBits'(1) << s1_ptr_q[bcc_pkg::WordIdxW-1:0]);
  assign out_of_range = s1_ptr_q[bcc_pkg::PtrW-1] || (s1_ptr_q >= bcc_pkg::PtrW'(limit));

  // Check of the beat in the check stage.
  always_comb begin
    cur_ino_d = cur_ino_q;
    enabled_d = enabled_q;
    skip_d    = skip_q;
    s1_we     = 1'b0;
    s1_emit   = 1'b0;
    s1_issue  = bcc_pkg::IssueBadMode;
    if (s1_go) begin
      unique case (s1_op_q)
        bcc_pkg::OpBegin: begin
          cur_ino_d = '0;
          enabled_d = 1'b0;
          skip_d    = 1'b0;
        end
        bcc_pkg::OpHeader: begin
          cur_ino_d = s1_ino_q;
          skip_d    = 1'b0;
          if (s1_mode_q == '0) begin
            enabled_d = 1'b0;
          end else if (s1_mode_q[bcc_pkg::ModeW-1:2] != '0) begin
            enabled_d = 1'b0;
            s1_emit   = 1'b1;
            s1_issue  = bcc_pkg::IssueBadMode;
          end else begin
            enabled_d = 1'b1;
          end
        end
        bcc_pkg::OpPointer: begin
          priority if (!enabled_q || (s1_kind_q == bcc_pkg::KindUnknown) ||
                       (s1_ptr_q == '0)) begin
            // Nothing to check.
          end else if ((s1_kind_q == bcc_pkg::KindEntry) && skip_q) begin
            // Entry of an invalid indirect block.
          end else if (out_of_range) begin
            if (s1_kind_q == bcc_pkg::KindIndirect) begin
              skip_d = 1'b1;
            end
            s1_emit  = 1'b1;
            s1_issue = bcc_pkg::IssueBadPointer;
          end else begin
            if (s1_kind_q == bcc_pkg::KindIndirect) begin
              skip_d = 1'b0;
            end
            if (bit_used) begin
              s1_emit  = 1'b1;
              s1_issue = bcc_pkg::IssueDuplicate;
            end else begin
              s1_we = 1'b1;
            end
          end
        end
        bcc_pkg::OpNone: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Stage, context, forwarding and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cur_ino_q   <= '0;
      enabled_q   <= 1'b0;
      skip_q      <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      cur_ino_q   <= cur_ino_d;
      enabled_q   <= enabled_d;
      skip_q      <= skip_d;
      fwd_valid_q <= s1_we && !sweep.busy;
      if (s1_go && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= bcc_pkg::op_e'(in_i.operation);
      s1_ino_q  <= in_i.inode_number;
      s1_mode_q <= in_i.inode_mode;
      s1_ptr_q  <= in_i.pointer_value;
      s1_kind_q <= bcc_pkg::kind_e'(in_i.pointer_kind);
    end
    if (s1_we) begin
      fwd_row_q  <= s1_row;
      fwd_data_q <= set_word;
    end
    if (s1_go && s1_emit) begin
      out_kind_q <= s1_issue;
      if (s1_issue == bcc_pkg::IssueBadMode) begin
        out_ino_q   <= s1_ino_q;
        out_block_q <= '0;
        out_pk_q    <= '0;
        out_mode_q  <= s1_mode_q;
      end else begin
        out_ino_q   <= cur_ino_q;
        out_block_q <= s1_ptr_q;
        out_pk_q    <= s1_kind_q;
        out_mode_q  <= '0;
      end
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.issue_kind         = out_kind_q;
  assign out_o.issue_inode        = out_ino_q;
  assign out_o.issue_block        = out_block_q;
  assign out_o.issue_pointer_kind = out_pk_q;
  assign out_o.issue_mode         = out_mode_q;

  // Bitmap sweep after reset and on begin.
  bcc_sweep u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s1_go && (s1_op_q == bcc_pkg::OpBegin)),
    .reserved_i (reserved),
    .ctl_o      (sweep)
  );

  // Bitmap memory; the sweep owns the write port while it runs.
  assign ram_we    = sweep.busy ? sweep.we : s1_we;
  assign ram_waddr = sweep.busy ? sweep.addr : s1_row;
  assign ram_wdata = sweep.busy ? sweep.data : set_word;

  bcc_ram #(
    .Width (bcc_pkg::WordBits),
    .Depth (bcc_pkg::Rows)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // No beat is taken while the bitmap is being swept.
  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep.busy |-> !in_i.ready)
    else $error("input beat taken during bitmap sweep");

  // The sweep and the check stage never write the bitmap in the same cycle.
  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep.busy && s1_we))
    else $error("bitmap write collision between sweep and check stage");

  // A begin leaving the check stage starts the sweep in the next cycle.
  a_begin_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_op_q == bcc_pkg::OpBegin)) |=> sweep.busy)
    else $error("begin did not start the bitmap sweep");

  // Only in-range pointers are marked in the bitmap.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_we |-> (s1_valid_q && !out_of_range && (s1_op_q == bcc_pkg::OpPointer)))
    else $error("bitmap marked for a pointer that is not in range");

endmodule
